// ===== hdl/bgtq_pkg.sv =====
// Shared types, constants and control interfaces of the backoff-gated transmit queue.
`timescale 1ns / 1ps

package bgtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int TIME_W          = 48;
  localparam int SEQ_W           = 16;
  localparam int ADDR_W          = 8;
  localparam int FLAGS_W         = 8;
  localparam int BODY_W          = 16;
  localparam int WAKE_W          = 32;
  localparam int DEPTH_W         = 4;
  localparam int NUM_DEST        = 256;

  localparam logic [SEQ_W-1:0]  SEQ_MAX  = 16'hFFFF;
  localparam logic [WAKE_W-1:0] WAKE_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ENQ_OK   = 2'd0,
    ENQ_DROP = 2'd1,
    ENQ_NONE = 2'd2
  } enq_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SEQ_WR,
    ST_DECIDE,
    ST_SCAN,
    ST_SHIFT,
    ST_WAKE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  dest;
    logic [SEQ_W-1:0]   seq;
    logic [FLAGS_W-1:0] flags;
    logic [BODY_W-1:0]  body;
    logic [TIME_W-1:0]  enq_ms;
    logic [TIME_W-1:0]  rdy_ms;
  } entry_t;

  typedef struct packed {
    logic load;
    logic seq_rd;
    logic seq_wr;
    logic scan;
    logic take;
    logic shift;
    logic pop;
    logic wake;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic is_send;
    logic busy;
    logic empty;
    logic pend;
    logic hit;
    logic last;
    logic shift_done;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/backoff_gated_tx_queue_top.sv =====
// Top level of the backoff-gated transmit queue: controller and datapath.
//
//   Channel   Direction  Handshake             Word
//   in_*      input      in_valid / in_ready   one send or drain request
//   out_*     output     out_valid / out_ready one result per request
//
// A drain passes through accept, prepare, decide and publish; a send adds its sequence update.
// An issue attempt scans the entries in FIFO order on the single entry memory read port, then
// either reports a wake time or shifts the entries behind the issued one forward.
// Reset is synchronous and empties the queue and all sequence counters at once.
// A new word is accepted while the last result waits; it then holds in its
// final cycle until the result register is free.
`timescale 1ns / 1ps

module backoff_gated_tx_queue_top
  import bgtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic [TIME_W-1:0]   in_now_ms,
  input  logic                in_radio_busy,
  input  logic [ADDR_W-1:0]   in_dest_addr,
  input  logic [FLAGS_W-1:0]  in_send_flags,
  input  logic [BODY_W-1:0]   in_body_handle,
  input  logic [TIME_W-1:0]   in_ready_at_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_enq_status,
  output logic [SEQ_W-1:0]    out_assigned_seq,
  output logic                out_issued,
  output logic [ADDR_W-1:0]   out_out_dest,
  output logic [SEQ_W-1:0]    out_out_seq,
  output logic [FLAGS_W-1:0]  out_out_flags,
  output logic [BODY_W-1:0]   out_out_body,
  output logic [TIME_W-1:0]   out_out_enqueued_ms,
  output logic                out_wake_valid,
  output logic [WAKE_W-1:0]   out_wake_delay_ms,
  output logic [DEPTH_W-1:0]  out_queue_depth
);

  cmd_t  cmd;
  stat_t stat;

  bgtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bgtq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_kind             (in_kind),
    .in_now_ms           (in_now_ms),
    .in_radio_busy       (in_radio_busy),
    .in_dest_addr        (in_dest_addr),
    .in_send_flags       (in_send_flags),
    .in_body_handle      (in_body_handle),
    .in_ready_at_ms      (in_ready_at_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_enq_status      (out_enq_status),
    .out_assigned_seq    (out_assigned_seq),
    .out_issued          (out_issued),
    .out_out_dest        (out_out_dest),
    .out_out_seq         (out_out_seq),
    .out_out_flags       (out_out_flags),
    .out_out_body        (out_out_body),
    .out_out_enqueued_ms (out_out_enqueued_ms),
    .out_wake_valid      (out_wake_valid),
    .out_wake_delay_ms   (out_wake_delay_ms),
    .out_queue_depth     (out_queue_depth),
    .cmd                 (cmd),
    .stat                (stat)
  );

endmodule

// ===== hdl/bgtq_ctrl.sv =====
// Sequencing state machine of the backoff-gated transmit queue.
`timescale 1ns / 1ps

module bgtq_ctrl
  import bgtq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (stat.is_send) begin
          cmd.seq_rd = 1'b1;
          state_nxt  = ST_SEQ_WR;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_SEQ_WR: begin
        cmd.seq_wr = 1'b1;
        state_nxt  = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = (stat.busy || stat.empty) ? ST_FIN : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.pend && stat.hit) begin
          cmd.take  = 1'b1;
          state_nxt = ST_SHIFT;
        end else if (stat.pend && stat.last) begin
          state_nxt = ST_WAKE;
        end
      end
      ST_SHIFT: begin
        if (stat.shift_done) begin
          cmd.pop   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      ST_WAKE: begin
        cmd.wake  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/bgtq_dp.sv =====
// Datapath of the backoff-gated transmit queue: sequence memory, entry memory and result registers.
`timescale 1ns / 1ps

module bgtq_dp
  import bgtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_kind,
  input  logic [TIME_W-1:0]   in_now_ms,
  input  logic                in_radio_busy,
  input  logic [ADDR_W-1:0]   in_dest_addr,
  input  logic [FLAGS_W-1:0]  in_send_flags,
  input  logic [BODY_W-1:0]   in_body_handle,
  input  logic [TIME_W-1:0]   in_ready_at_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_enq_status,
  output logic [SEQ_W-1:0]    out_assigned_seq,
  output logic                out_issued,
  output logic [ADDR_W-1:0]   out_out_dest,
  output logic [SEQ_W-1:0]    out_out_seq,
  output logic [FLAGS_W-1:0]  out_out_flags,
  output logic [BODY_W-1:0]   out_out_body,
  output logic [TIME_W-1:0]   out_out_enqueued_ms,
  output logic                out_wake_valid,
  output logic [WAKE_W-1:0]   out_wake_delay_ms,
  output logic [DEPTH_W-1:0]  out_queue_depth,
  input  cmd_t                cmd,
  output stat_t               stat
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic                kind_r;
  logic                busy_r;
  logic [TIME_W-1:0]   now_r;
  logic [ADDR_W-1:0]   dest_r;
  logic [FLAGS_W-1:0]  flags_r;
  logic [BODY_W-1:0]   body_r;
  logic [TIME_W-1:0]   rdy_r;

  logic [SEQ_W-1:0]    seq_mem [NUM_DEST];
  logic [NUM_DEST-1:0] seq_vld_r;
  logic [SEQ_W-1:0]    seq_q_r;
  logic                seq_hit_r;
  logic [SEQ_W-1:0]    cur_seq;
  logic [SEQ_W-1:0]    new_seq;

  entry_t              q_mem [QUEUE_DEPTH];
  entry_t              q_rdata_r;
  logic                q_we;
  logic [AW-1:0]       q_wa;
  entry_t              q_wd;

  logic [CW-1:0]       count_r;
  logic [CW-1:0]       rd_idx_r;
  logic [CW-1:0]       cmp_idx_r;
  logic [CW-1:0]       wr_idx_r;
  logic                pend_r;
  logic [TIME_W-1:0]   soonest_r;
  logic                full;
  logic                rd_more;
  logic                hit;
  logic [TIME_W-1:0]   diff;
  logic [CW+3:0]       cnt_ext;

  enq_status_t         res_status_r;
  logic [SEQ_W-1:0]    res_seq_r;
  logic                res_issued_r;
  entry_t              res_ent_r;
  logic                res_wake_r;
  logic [WAKE_W-1:0]   res_delay_r;

  enq_status_t         o_status_r;
  logic [SEQ_W-1:0]    o_seq_r;
  logic                o_issued_r;
  entry_t              o_ent_r;
  logic                o_wake_r;
  logic [WAKE_W-1:0]   o_delay_r;
  logic [DEPTH_W-1:0]  o_depth_r;
  logic                out_valid_r;

  assign cur_seq = seq_hit_r ? seq_q_r : '0;
  assign new_seq = (cur_seq == SEQ_MAX) ? SEQ_W'(1) : cur_seq + SEQ_W'(1);
  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign rd_more = (rd_idx_r < count_r);
  assign hit     = (q_rdata_r.rdy_ms <= now_r);
  assign diff    = soonest_r - now_r;
  assign cnt_ext = {4'b0000, count_r};

  always_comb begin
    q_we = (cmd.seq_wr && !full) || (cmd.shift && pend_r);
    q_wa = cmd.seq_wr ? count_r[AW-1:0] : wr_idx_r[AW-1:0];
    if (cmd.seq_wr) begin
      q_wd.dest   = dest_r;
      q_wd.seq    = new_seq;
      q_wd.flags  = flags_r;
      q_wd.body   = body_r;
      q_wd.enq_ms = now_r;
      q_wd.rdy_ms = rdy_r;
    end else begin
      q_wd = q_rdata_r;
    end
  end

  always_comb begin
    stat.is_send    = !kind_r;
    stat.busy       = busy_r;
    stat.empty      = (count_r == '0);
    stat.pend       = pend_r;
    stat.hit        = hit;
    stat.last       = ((cmp_idx_r + CW'(1)) == count_r);
    stat.shift_done = !pend_r && !rd_more;
    stat.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.seq_wr) begin
      seq_mem[dest_r] <= new_seq;
    end
    if (cmd.seq_rd) begin
      seq_q_r <= seq_mem[dest_r];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    if (cmd.scan || (cmd.shift && rd_more)) begin
      q_rdata_r <= q_mem[rd_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      seq_vld_r   <= '0;
    end else begin
      if (cmd.seq_wr) begin
        seq_vld_r[dest_r] <= 1'b1;
        if (!full) begin
          count_r <= count_r + CW'(1);
        end
      end
      if (cmd.pop) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.load || cmd.take) begin
        pend_r <= 1'b0;
      end else if (cmd.scan) begin
        pend_r <= 1'b1;
      end else if (cmd.shift) begin
        pend_r <= rd_more;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r       <= in_kind;
      busy_r       <= in_radio_busy;
      now_r        <= in_now_ms;
      dest_r       <= in_dest_addr;
      flags_r      <= in_send_flags;
      body_r       <= in_body_handle;
      rdy_r        <= in_ready_at_ms;
      res_status_r <= in_kind ? ENQ_NONE : ENQ_OK;
      res_seq_r    <= '0;
      res_issued_r <= 1'b0;
      res_ent_r    <= '0;
      res_wake_r   <= 1'b0;
      res_delay_r  <= '0;
      rd_idx_r     <= '0;
      soonest_r    <= '1;
    end
    if (cmd.seq_rd) begin
      seq_hit_r <= seq_vld_r[dest_r];
    end
    if (cmd.seq_wr) begin
      res_seq_r    <= new_seq;
      res_status_r <= full ? ENQ_DROP : ENQ_OK;
    end
    if (cmd.scan) begin
      cmp_idx_r <= rd_idx_r;
      if (pend_r && !hit && (q_rdata_r.rdy_ms < soonest_r)) begin
        soonest_r <= q_rdata_r.rdy_ms;
      end
    end
    if (cmd.shift && pend_r) begin
      wr_idx_r <= wr_idx_r + CW'(1);
    end
    if (cmd.take) begin
      res_issued_r <= 1'b1;
      res_ent_r    <= q_rdata_r;
      wr_idx_r     <= cmp_idx_r;
      rd_idx_r     <= cmp_idx_r + CW'(1);
    end else if (cmd.scan || (cmd.shift && rd_more)) begin
      rd_idx_r <= rd_idx_r + CW'(1);
    end
    if (cmd.wake) begin
      res_wake_r  <= 1'b1;
      res_delay_r <= (diff[TIME_W-1:WAKE_W] != '0) ? WAKE_MAX : diff[WAKE_W-1:0];
    end
    if (cmd.publish) begin
      o_status_r <= res_status_r;
      o_seq_r    <= res_seq_r;
      o_issued_r <= res_issued_r;
      o_ent_r    <= res_ent_r;
      o_wake_r   <= res_wake_r;
      o_delay_r  <= res_delay_r;
      o_depth_r  <= cnt_ext[DEPTH_W-1:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_enq_status      = o_status_r;
  assign out_assigned_seq    = o_seq_r;
  assign out_issued          = o_issued_r;
  assign out_out_dest        = o_ent_r.dest;
  assign out_out_seq         = o_ent_r.seq;
  assign out_out_flags       = o_ent_r.flags;
  assign out_out_body        = o_ent_r.body;
  assign out_out_enqueued_ms = o_ent_r.enq_ms;
  assign out_wake_valid      = o_wake_r;
  assign out_wake_delay_ms   = o_delay_r;
  assign out_queue_depth     = o_depth_r;

endmodule

// ===== hdl/bgtq_chk.sv =====
// Port-level checker of the backoff-gated transmit queue and its bind to the top level.
`timescale 1ns / 1ps

module bgtq_chk
  import bgtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_enq_status,
  input logic [SEQ_W-1:0]   out_assigned_seq,
  input logic               out_issued,
  input logic               out_wake_valid,
  input logic [DEPTH_W-1:0] out_queue_depth
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_assigned_seq))
    else $error("result word changed while stalled");

  a_issue_or_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_issued |-> !out_wake_valid)
    else $error("issued word also reports a wake time");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (QUEUE_DEPTH > 15) || (out_queue_depth <= QUEUE_DEPTH))
    else $error("queue depth beyond capacity");

  a_seq_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_enq_status == ENQ_NONE && out_assigned_seq == '0) ||
                  ((out_enq_status == ENQ_OK || out_enq_status == ENQ_DROP) &&
                   out_assigned_seq != '0))
    else $error("sequence value does not match send status");

endmodule

bind backoff_gated_tx_queue_top bgtq_chk #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_bgtq_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_enq_status   (out_enq_status),
  .out_assigned_seq (out_assigned_seq),
  .out_issued       (out_issued),
  .out_wake_valid   (out_wake_valid),
  .out_queue_depth  (out_queue_depth)
);

// ===== sim/backoff_gated_tx_queue_top_tb.sv =====
// Self-checking testbench of the backoff-gated transmit queue with a clocked driver and monitor.
`timescale 1ns / 1ps

module backoff_gated_tx_queue_top_tb;
  import bgtq_pkg::*;

  localparam logic KIND_SEND  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam int N_DIRECTED  = 26;
  localparam int N_BURST     = 300;
  localparam int N_RANDOM    = 1474;
  localparam int NO_IDLE_LO  = N_DIRECTED;
  localparam int NO_IDLE_HI  = N_DIRECTED + N_BURST;
  localparam int HOLD_AT     = NO_IDLE_HI + 300;
  localparam int HOLD_LEN    = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int PRINT_MAX   = 20;

  typedef struct {
    logic               kind;
    logic [TIME_W-1:0]  now;
    logic               busy;
    logic [ADDR_W-1:0]  dest;
    logic [FLAGS_W-1:0] flags;
    logic [BODY_W-1:0]  body;
    logic [TIME_W-1:0]  rdy;
    logic               pause;
  } tx_req_t;

  typedef struct packed {
    enq_status_t        status;
    logic [SEQ_W-1:0]   seq;
    logic               issued;
    logic [ADDR_W-1:0]  dest;
    logic [SEQ_W-1:0]   oseq;
    logic [FLAGS_W-1:0] flags;
    logic [BODY_W-1:0]  body;
    logic [TIME_W-1:0]  enq_ms;
    logic               wake;
    logic [WAKE_W-1:0]  wake_ms;
    logic [DEPTH_W-1:0] depth;
  } tx_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic in_radio_busy = 1'b0;
  logic [ADDR_W-1:0] in_dest_addr = '0;
  logic [FLAGS_W-1:0] in_send_flags = '0;
  logic [BODY_W-1:0] in_body_handle = '0;
  logic [TIME_W-1:0] in_ready_at_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_enq_status;
  logic [SEQ_W-1:0] out_assigned_seq;
  logic out_issued;
  logic [ADDR_W-1:0] out_out_dest;
  logic [SEQ_W-1:0] out_out_seq;
  logic [FLAGS_W-1:0] out_out_flags;
  logic [BODY_W-1:0] out_out_body;
  logic [TIME_W-1:0] out_out_enqueued_ms;
  logic out_wake_valid;
  logic [WAKE_W-1:0] out_wake_delay_ms;
  logic [DEPTH_W-1:0] out_queue_depth;

  tx_req_t    pending_q[$];
  tx_result_t result_q[$];
  tx_req_t    cur_req;

  logic [SEQ_W-1:0] seq_tab[NUM_DEST];
  entry_t slots[QUEUE_DEPTH_DEF];
  int fill = 0;

  int sent_cnt = 0;
  int recv_cnt = 0;
  int popped = 0;
  int fault_cnt = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int n_send = 0, n_drop = 0, n_issue = 0, n_wake = 0, n_wrap = 0, n_sat = 0;

  backoff_gated_tx_queue_top #(.QUEUE_DEPTH(QUEUE_DEPTH_DEF)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_now_ms           (in_now_ms),
    .in_radio_busy       (in_radio_busy),
    .in_dest_addr        (in_dest_addr),
    .in_send_flags       (in_send_flags),
    .in_body_handle      (in_body_handle),
    .in_ready_at_ms      (in_ready_at_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_enq_status      (out_enq_status),
    .out_assigned_seq    (out_assigned_seq),
    .out_issued          (out_issued),
    .out_out_dest        (out_out_dest),
    .out_out_seq         (out_out_seq),
    .out_out_flags       (out_out_flags),
    .out_out_body        (out_out_body),
    .out_out_enqueued_ms (out_out_enqueued_ms),
    .out_wake_valid      (out_wake_valid),
    .out_wake_delay_ms   (out_wake_delay_ms),
    .out_queue_depth     (out_queue_depth)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NUM_DEST; i++) seq_tab[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_fault(input string msg);
    fault_cnt++;
    if (fault_cnt <= PRINT_MAX) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want, input int idx);
    if (got != want)
      report_fault($sformatf("word %0d: %s is %0h, expected %0h", idx, name, got, want));
  endtask

  function automatic logic [TIME_W-1:0] rnd48();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[TIME_W-1:0];
  endfunction

  function automatic tx_req_t make_req(input logic kind, input logic [TIME_W-1:0] now,
                                       input logic busy, input logic [ADDR_W-1:0] dest,
                                       input logic [FLAGS_W-1:0] flags,
                                       input logic [BODY_W-1:0] body,
                                       input logic [TIME_W-1:0] rdy);
    tx_req_t r;
    r.kind = kind;
    r.now = now;
    r.busy = busy;
    r.dest = dest;
    r.flags = flags;
    r.body = body;
    r.rdy = rdy;
    r.pause = 1'b0;
    return r;
  endfunction

  // Sequence numbering, enqueue or drop; if not busy, a FIFO scan for the first ready entry.
  function automatic tx_result_t run_queue(input tx_req_t r);
    tx_result_t res;
    logic [SEQ_W-1:0] nseq;
    logic [TIME_W-1:0] soonest;
    logic [TIME_W-1:0] gap;
    int pick;
    int i;
    res = '0;
    if (r.kind == KIND_SEND) begin
      n_send++;
      if (seq_tab[r.dest] == SEQ_MAX) begin
        nseq = 16'd1;
        n_wrap++;
      end else begin
        nseq = seq_tab[r.dest] + 16'd1;
      end
      seq_tab[r.dest] = nseq;
      res.seq = nseq;
      if (fill < QUEUE_DEPTH_DEF) begin
        slots[fill] = '{dest: r.dest, seq: nseq, flags: r.flags, body: r.body,
                        enq_ms: r.now, rdy_ms: r.rdy};
        fill++;
        res.status = ENQ_OK;
      end else begin
        res.status = ENQ_DROP;
        n_drop++;
      end
    end else begin
      res.status = ENQ_NONE;
    end
    if (!r.busy && fill > 0) begin
      pick = -1;
      soonest = '1;
      for (i = 0; i < fill; i++) begin
        if (pick < 0) begin
          if (slots[i].rdy_ms <= r.now) pick = i;
          else if (slots[i].rdy_ms < soonest) soonest = slots[i].rdy_ms;
        end
      end
      if (pick >= 0) begin
        n_issue++;
        res.issued = 1'b1;
        res.dest = slots[pick].dest;
        res.oseq = slots[pick].seq;
        res.flags = slots[pick].flags;
        res.body = slots[pick].body;
        res.enq_ms = slots[pick].enq_ms;
        for (i = pick; i < fill - 1; i++) slots[i] = slots[i + 1];
        fill--;
      end else begin
        n_wake++;
        gap = soonest - r.now;
        res.wake = 1'b1;
        if (gap > {16'd0, WAKE_MAX}) begin
          res.wake_ms = WAKE_MAX;
          n_sat++;
        end else begin
          res.wake_ms = gap[WAKE_W-1:0];
        end
      end
    end
    res.depth = fill[DEPTH_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : drive
    tx_req_t nxt;
    int done_now;
    logic go;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      done_now = sent_cnt;
      if (in_valid && in_ready) begin
        result_q.push_back(run_queue(cur_req));
        done_now = sent_cnt + 1;
        sent_cnt <= done_now;
      end
      if (!in_valid || in_ready) begin
        go = 1'b0;
        if (pending_q.size() != 0) begin
          go = (popped >= NO_IDLE_LO && popped < NO_IDLE_HI) || $urandom_range(0, 99) >= 29;
          if (pending_q[0].pause && done_now != recv_cnt) go = 1'b0;
        end
        if (go) begin
          nxt = pending_q.pop_front();
          cur_req <= nxt;
          in_kind <= nxt.kind;
          in_now_ms <= nxt.now;
          in_radio_busy <= nxt.busy;
          in_dest_addr <= nxt.dest;
          in_send_flags <= nxt.flags;
          in_body_handle <= nxt.body;
          in_ready_at_ms <= nxt.rdy;
          popped <= popped + 1;
        end
        in_valid <= go;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= (hold_left == 1);
    end else if (!hold_done && recv_cnt >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (recv_cnt >= NO_IDLE_LO && recv_cnt < NO_IDLE_HI) ||
                   $urandom_range(0, 99) >= 29;
    end
  end

  always @(posedge clk) begin : monitor
    tx_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        report_fault($sformatf("word %0d arrived with no request outstanding", recv_cnt));
      end else begin
        want = result_q.pop_front();
        check_field("enq_status", out_enq_status, want.status, recv_cnt);
        check_field("assigned_seq", out_assigned_seq, want.seq, recv_cnt);
        check_field("issued", out_issued, want.issued, recv_cnt);
        check_field("out_dest", out_out_dest, want.dest, recv_cnt);
        check_field("out_seq", out_out_seq, want.oseq, recv_cnt);
        check_field("out_flags", out_out_flags, want.flags, recv_cnt);
        check_field("out_body", out_out_body, want.body, recv_cnt);
        check_field("out_enqueued_ms", out_out_enqueued_ms, want.enq_ms, recv_cnt);
        check_field("wake_valid", out_wake_valid, want.wake, recv_cnt);
        check_field("wake_delay_ms", out_wake_delay_ms, want.wake_ms, recv_cnt);
        check_field("queue_depth", out_queue_depth, want.depth, recv_cnt);
      end
      recv_cnt <= recv_cnt + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("backoff_gated_tx_queue_top_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    tx_req_t r;
    logic [TIME_W-1:0] clk_ms;
    logic [TIME_W-1:0] nowv;
    logic [TIME_W-1:0] rdyv;
    int k;
    int sel;

    // Empty drain, field extremes, busy radio, skip-over issue, saturated and plain wake.
    pending_q.push_back(make_req(KIND_DRAIN, '0, 1'b0, '0, '0, '0, '0));
    pending_q.push_back(make_req(KIND_SEND, '0, 1'b0, 8'h00, 8'h00, 16'h0000, '0));
    pending_q.push_back(make_req(KIND_SEND, TIME_MAX, 1'b0, 8'hFF, 8'hFF, 16'hFFFF, '0));
    pending_q.push_back(make_req(KIND_SEND, 48'd10, 1'b1, 8'h01, 8'h5A, 16'h1234, '0));
    pending_q.push_back(make_req(KIND_SEND, 48'd20, 1'b1, 8'h02, 8'hA5, 16'hEDCB, TIME_MAX));
    pending_q.push_back(make_req(KIND_DRAIN, 48'd30, 1'b0, '0, '0, '0, '0));
    pending_q.push_back(make_req(KIND_DRAIN, 48'd40, 1'b0, '0, '0, '0, '0));
    pending_q.push_back(make_req(KIND_SEND, 48'd50, 1'b1, 8'h03, 8'h0F, 16'h00FF, 48'd1000));
    pending_q.push_back(make_req(KIND_DRAIN, 48'd60, 1'b0, '0, '0, '0, '0));
    pending_q.push_back(make_req(KIND_DRAIN, 48'd1000, 1'b0, '0, '0, '0, '0));
    for (k = 0; k < 7; k++)
      pending_q.push_back(make_req(KIND_SEND, 48'd2000, 1'b1, 8'(k + 4), 8'($urandom),
                                   16'($urandom), rnd48()));
    // The queue is full now: a drop with the radio busy, then a drop that still issues.
    pending_q.push_back(make_req(KIND_SEND, 48'd2001, 1'b1, 8'h00, 8'h11, 16'h2222, '0));
    pending_q.push_back(make_req(KIND_SEND, TIME_MAX, 1'b0, 8'h00, 8'h33, 16'h4444, '0));
    for (k = 0; k < 7; k++)
      pending_q.push_back(make_req(KIND_DRAIN, TIME_MAX, 1'b0, '0, '0, '0, '0));

    // A back-to-back burst of sends to one destination.
    for (k = 0; k < N_BURST; k++)
      pending_q.push_back(make_req(KIND_SEND, 48'd5000 + TIME_W'(k), 1'b0, 8'hA5,
                                   8'($urandom), 16'($urandom), '0));

    clk_ms = 48'd100000;
    for (k = 0; k < N_RANDOM; k++) begin
      clk_ms = clk_ms + TIME_W'($urandom_range(0, 40));
      nowv = clk_ms;
      sel = $urandom_range(0, 99);
      if (sel < 2) nowv = rnd48();
      else if (sel < 5) nowv = TIME_MAX;
      sel = $urandom_range(0, 99);
      if (sel < 30) rdyv = '0;
      else if (sel < 55) rdyv = (nowv > 48'd30) ? nowv - TIME_W'($urandom_range(0, 30)) : '0;
      else if (sel < 88) rdyv = nowv + TIME_W'($urandom_range(1, 150));
      else if (sel < 92) rdyv = nowv + 48'hFFFF_FFFF;
      else if (sel < 95) rdyv = nowv + 48'h1_0000_0000;
      else rdyv = rnd48();
      r = make_req(($urandom_range(0, 99) < 60) ? KIND_SEND : KIND_DRAIN, nowv,
                   $urandom_range(0, 99) < 20,
                   ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 7)),
                   8'($urandom), 16'($urandom), rdyv);
      r.pause = (k == 0 || k == 900);
      pending_q.push_back(r);
    end

    @(posedge clk);
    while (pending_q.size() != 0 || in_valid || sent_cnt != recv_cnt) @(posedge clk);
    repeat (40) @(posedge clk);
    if (result_q.size() != 0)
      report_fault($sformatf("%0d results never arrived", result_q.size()));
    $display("Ran %0d requests: %0d sends, %0d drops, %0d issues, %0d wake reports",
             sent_cnt, n_send, n_drop, n_issue, n_wake);
    $display("Sequence wraps seen: %0d, saturated wake delays: %0d, mismatches: %0d",
             n_wrap, n_sat, fault_cnt);
    if (fault_cnt == 0) begin
      $display("backoff_gated_tx_queue_top_tb OK");
    end else begin
      $display("backoff_gated_tx_queue_top_tb NOT OK");
    end
    $finish;
  end

endmodule
